>>> hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned ListDepthDef = 1024;
  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned ActionW      = 3;
  localparam int unsigned PosW         = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountOutW    = 11;

  typedef enum logic [ActionW-1:0] {
    ACT_READ   = 3'd0,
    ACT_FRONT  = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_DELETE = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request and decode
    logic rd_issue;  // issue memory read at the walk pointer, or one below it for an insert
    logic mv_up;     // write read data one slot up, step pointer down
    logic mv_dn;     // write read data one slot down, step pointer up
    logic wr_new;    // write the new word at the insert position
    logic finish;    // update count and publish result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_read;
    logic is_insert;
    logic is_delete;
    logic walk_done;
  } sts_t;

endpackage

>>> hw/rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed words with read, insert and delete by position.
//
// Channel   Direction  Handshake          Fields
// request   in         start / busy       action_i, position_i, value_i
// result    out        valid_o strobe     read_word_o, hit_o, applied_o,
//                                         full_refused_o, entry_count_o
//
// A read, an ignored request or a refused insert goes from the read state
// to the done state, which registers the result for its beat; the next request
// can be accepted only after the beat. A delete or an insert first moves
// entries one at a time, each move reading the entry memory into a register
// and then writing it one slot down or up; an insert then writes the new word.
// Reset clears the count, pointer, flags and result outputs; the entry memory
// needs no clearing. The result beat lasts one cycle and cannot be stalled;
// busy stays high until it has been shown.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int unsigned ListDepth = ils_pkg::ListDepthDef,
  parameter int unsigned WordWidth = ils_pkg::WordWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [ils_pkg::ActionW-1:0]       action_i,
  input  logic [ils_pkg::PosW-1:0]          position_i,
  input  logic signed [ils_pkg::ValueW-1:0] value_i,
  output logic                              valid_o,
  output logic signed [ils_pkg::ValueW-1:0] read_word_o,
  output logic                              hit_o,
  output logic                              applied_o,
  output logic                              full_refused_o,
  output logic [ils_pkg::CountOutW-1:0]     entry_count_o
);

  ils_pkg::cmd_t cmd;
  ils_pkg::sts_t sts;
  logic          ctrl_busy, ctrl_start, done, valid_q;

  assign ctrl_start = start & ~valid_q;

  ils_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (ctrl_start),
    .busy   (ctrl_busy),
    .done_o (done),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ils_datapath #(
    .ListDepth (ListDepth),
    .WordWidth (WordWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .read_word_o    (read_word_o),
    .hit_o          (hit_o),
    .applied_o      (applied_o),
    .full_refused_o (full_refused_o),
    .entry_count_o  (entry_count_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done;
    end
  end

  assign valid_o = valid_q;
  assign busy    = ctrl_busy | valid_q;

  a_hit_applied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> applied_o && !full_refused_o)
    else $error("hit without applied");
  a_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && full_refused_o |-> !applied_o && !hit_o)
    else $error("refused request reported applied");
  a_one_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result beat longer than one cycle");
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

endmodule

>>> hw/rtl/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath
// Entry memory, count, walk pointer and result registers of the list store.
// ----------------------------------------------------------------------------
module ils_datapath #(
  parameter int unsigned ListDepth = ils_pkg::ListDepthDef,
  parameter int unsigned WordWidth = ils_pkg::WordWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ils_pkg::ActionW-1:0]     action_i,
  input  logic [ils_pkg::PosW-1:0]        position_i,
  input  logic signed [ils_pkg::ValueW-1:0] value_i,
  input  ils_pkg::cmd_t                   cmd_i,
  output ils_pkg::sts_t                   sts_o,
  output logic signed [ils_pkg::ValueW-1:0] read_word_o,
  output logic                            hit_o,
  output logic                            applied_o,
  output logic                            full_refused_o,
  output logic [ils_pkg::CountOutW-1:0]   entry_count_o
);

  localparam int unsigned AddrW = $clog2(ListDepth);
  localparam int unsigned CntW  = $clog2(ListDepth + 1);
  localparam int unsigned CmpW  = (CntW > ils_pkg::PosW) ? CntW : ils_pkg::PosW;

  logic [WordWidth-1:0] mem [ListDepth];
  logic [WordWidth-1:0] rdata_q;

  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      ptr_q, ptr_d;
  logic [CntW-1:0]      ins_q;
  logic [WordWidth-1:0] word_q;
  logic                 is_read_q, is_ins_q, is_del_q, refused_q;

  logic [CmpW-1:0] pos_x, cnt_x;
  logic            pos_lt, pos_le, full;
  logic [CntW-1:0] pos_c;

  assign pos_x  = CmpW'(position_i);
  assign cnt_x  = CmpW'(count_q);
  assign pos_lt = pos_x < cnt_x;
  assign pos_le = pos_x <= cnt_x;
  assign full   = count_q >= CntW'(ListDepth);
  assign pos_c  = CntW'(position_i);

  logic       dec_read, dec_ins, dec_del, dec_ref;
  logic [CntW-1:0] dec_ins_pos;

  always_comb begin
    dec_read    = 1'b0;
    dec_ins     = 1'b0;
    dec_del     = 1'b0;
    dec_ref     = 1'b0;
    dec_ins_pos = '0;
    case (action_i)
      ils_pkg::ACT_READ:   dec_read = pos_lt;
      ils_pkg::ACT_FRONT:  dec_ins = 1'b1;
      ils_pkg::ACT_APPEND: begin
        dec_ins     = 1'b1;
        dec_ins_pos = count_q;
      end
      ils_pkg::ACT_INSERT: begin
        dec_ins     = pos_le;
        dec_ins_pos = pos_c;
      end
      ils_pkg::ACT_DELETE: dec_del = pos_lt;
      default: ;
    endcase
    if (dec_ins && full) begin
      dec_ins = 1'b0;
      dec_ref = 1'b1;
    end
  end

  // Insert walks from the top down; delete walks from position+1 up.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      if (dec_read) ptr_d = pos_c;
      else if (dec_del) ptr_d = pos_c + CntW'(1);
      else ptr_d = count_q;
    end else if (cmd_i.mv_up) begin
      ptr_d = ptr_q - CntW'(1);
    end else if (cmd_i.mv_dn) begin
      ptr_d = ptr_q + CntW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish) begin
      if (is_ins_q) count_d = count_q + CntW'(1);
      else if (is_del_q) count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      is_read_q <= 1'b0;
      is_ins_q  <= 1'b0;
      is_del_q  <= 1'b0;
      refused_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load) begin
        is_read_q <= dec_read;
        is_ins_q  <= dec_ins;
        is_del_q  <= dec_del;
        refused_q <= dec_ref;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ins_q  <= dec_ins_pos;
      word_q <= WordWidth'($signed(value_i));
    end
  end

  // Memory: one read and one write port, registered read data.
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordWidth-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[AddrW-1:0];
    wdata = rdata_q;
    if (cmd_i.mv_up) begin
      we    = 1'b1;
      waddr = AddrW'(ptr_q);
    end else if (cmd_i.mv_dn) begin
      we    = 1'b1;
      waddr = AddrW'(ptr_q - CntW'(1));
    end else if (cmd_i.wr_new) begin
      we    = 1'b1;
      waddr = ins_q[AddrW-1:0];
      wdata = word_q;
    end
  end

  logic [AddrW-1:0] raddr;
  assign raddr = cmd_i.mv_up ? AddrW'(ptr_q - CntW'(2)) :
                 cmd_i.mv_dn ? AddrW'(ptr_q + CntW'(1)) :
                 (is_ins_q ? AddrW'(ptr_q - CntW'(1)) : AddrW'(ptr_q));

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_issue || cmd_i.mv_up || cmd_i.mv_dn) rdata_q <= mem[raddr];
  end

  assign sts_o.is_read   = is_read_q;
  assign sts_o.is_insert = is_ins_q;
  assign sts_o.is_delete = is_del_q;
  assign sts_o.walk_done = is_ins_q ? (ptr_q == ins_q) : (ptr_q >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_o          <= 1'b0;
      applied_o      <= 1'b0;
      full_refused_o <= 1'b0;
      read_word_o    <= '1;
      entry_count_o  <= '0;
    end else if (cmd_i.finish) begin
      hit_o          <= is_read_q;
      applied_o      <= is_read_q | is_ins_q | is_del_q;
      full_refused_o <= refused_q;
      read_word_o    <= is_read_q ? ils_pkg::ValueW'($signed(rdata_q)) : '1;
      entry_count_o  <= ils_pkg::CountOutW'(count_d);
    end
  end

endmodule

>>> hw/rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for read, shift and write steps of the list store.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ils_pkg::sts_t sts_i,
  output ils_pkg::cmd_t cmd_o
);

  ils_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ils_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ils_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ils_pkg::ST_READ;
        end
      end
      ils_pkg::ST_READ: begin
        if (sts_i.is_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ils_pkg::ST_DONE;
        end else if (sts_i.is_insert) begin
          if (sts_i.walk_done) begin
            state_d = ils_pkg::ST_WRITE;
          end else begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ils_pkg::ST_SHIFT_UP;
          end
        end else if (sts_i.is_delete) begin
          if (sts_i.walk_done) begin
            state_d = ils_pkg::ST_DONE;
          end else begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ils_pkg::ST_SHIFT_DN;
          end
        end else begin
          state_d = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::ST_SHIFT_UP: begin
        cmd_o.mv_up = 1'b1;
        state_d     = ils_pkg::ST_READ;
      end
      ils_pkg::ST_SHIFT_DN: begin
        cmd_o.mv_dn = 1'b1;
        state_d     = ils_pkg::ST_READ;
      end
      ils_pkg::ST_WRITE: begin
        cmd_o.wr_new = 1'b1;
        state_d      = ils_pkg::ST_DONE;
      end
      ils_pkg::ST_DONE: begin
        cmd_o.finish = 1'b1;
        done_o       = 1'b1;
        state_d      = ils_pkg::ST_IDLE;
      end
      default: state_d = ils_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the indexed list store. A directed table covers
// the empty list, the extreme words and positions, every action and the
// ignored codes. Random traffic then runs on a short list and finishes with
// a stretch of back to back requests with no idling.
// Every result beat is compared field by field with the table's outcome or a list predictor.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycLimit = 4_000_000;

  typedef struct packed {
    logic signed [ils_pkg::ValueW-1:0] read_word;
    logic                              hit;
    logic                              applied;
    logic                              full_refused;
    logic [ils_pkg::CountOutW-1:0]     entry_count;
  } outcome_t;

  typedef struct packed {
    logic [ils_pkg::ActionW-1:0]       action;
    logic [ils_pkg::PosW-1:0]          position;
    logic signed [ils_pkg::ValueW-1:0] value;
    logic                              typed;
    outcome_t                          outcome;
  } row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [ils_pkg::ActionW-1:0]       action_i;
  logic [ils_pkg::PosW-1:0]          position_i;
  logic signed [ils_pkg::ValueW-1:0] value_i;
  logic                              valid_o;
  logic signed [ils_pkg::ValueW-1:0] read_word_o;
  logic                              hit_o;
  logic                              applied_o;
  logic                              full_refused_o;
  logic [ils_pkg::CountOutW-1:0]     entry_count_o;

  logic signed [ils_pkg::ValueW-1:0] list_words[$];
  outcome_t                          pending_outcomes[$];
  int unsigned                       error_cnt;
  int unsigned                       beat_cnt;
  int unsigned                       item_cnt;
  int unsigned                       cycle_cnt;
  bit                                idle_en;

  indexed_list_store i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .read_word_o    (read_word_o),
    .hit_o          (hit_o),
    .applied_o      (applied_o),
    .full_refused_o (full_refused_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic outcome_t apply_request(logic [ils_pkg::ActionW-1:0] act,
                                             logic [ils_pkg::PosW-1:0] pos,
                                             logic signed [ils_pkg::ValueW-1:0] val);
    outcome_t    o;
    int unsigned n;
    bit          ins;
    int unsigned at;
    n = list_words.size();
    o = '{read_word: -1, hit: 1'b0, applied: 1'b0, full_refused: 1'b0, entry_count: '0};
    ins = 1'b0;
    at = 0;
    case (act)
      ils_pkg::ACT_READ: begin
        if (pos < n) begin
          o.read_word = list_words[pos];
          o.hit = 1'b1;
          o.applied = 1'b1;
        end
      end
      ils_pkg::ACT_FRONT: ins = 1'b1;
      ils_pkg::ACT_APPEND: begin
        ins = 1'b1;
        at = n;
      end
      ils_pkg::ACT_INSERT: begin
        if (pos <= n) begin
          ins = 1'b1;
          at = pos;
        end
      end
      ils_pkg::ACT_DELETE: begin
        if (pos < n) begin
          list_words.delete(pos);
          o.applied = 1'b1;
        end
      end
      default: ;
    endcase
    if (ins) begin
      if (n >= ils_pkg::ListDepthDef) begin
        o.full_refused = 1'b1;
      end else begin
        list_words.insert(at, val);
        o.applied = 1'b1;
      end
    end
    o.entry_count = ils_pkg::CountOutW'(list_words.size());
    return o;
  endfunction

  task automatic send(logic [ils_pkg::ActionW-1:0] act, logic [ils_pkg::PosW-1:0] pos,
                      logic signed [ils_pkg::ValueW-1:0] val, bit typed,
                      outcome_t typed_out);
    int unsigned gap;
    outcome_t    o;
    if (idle_en && $urandom_range(3) == 0) begin
      gap = $urandom_range(4, 1);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start      = 1'b1;
    action_i   = act;
    position_i = pos;
    value_i    = val;
    do @(posedge clk_i); while (busy);
    o = apply_request(act, pos, val);
    pending_outcomes.push_back(typed ? typed_out : o);
    item_cnt++;
  endtask

  function automatic logic signed [ils_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ils_pkg::PosW-1:0] pick_pos();
    int unsigned n;
    n = list_words.size();
    case ($urandom_range(9))
      0: return ils_pkg::PosW'($urandom);
      1: return ils_pkg::PosW'(n);
      2: return ils_pkg::PosW'((n > 0) ? n - 1 : 0);
      default: return ils_pkg::PosW'($urandom_range(n + 1));
    endcase
  endfunction

  task automatic send_random(bit keep_short);
    logic [ils_pkg::ActionW-1:0] act;
    outcome_t                    none;
    none = '0;
    if ($urandom_range(19) == 0) begin
      act = ils_pkg::ActionW'($urandom_range(7, 5));
    end else if (keep_short && list_words.size() > 40 && $urandom_range(1)) begin
      act = ils_pkg::ACT_DELETE;
    end else begin
      act = ils_pkg::ActionW'($urandom_range(4));
    end
    send(act, pick_pos(), pick_value(), 1'b0, none);
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (valid_o) begin
      beat_cnt++;
      if (pending_outcomes.size() == 0) begin
        $error("Result beat with nothing expected");
        error_cnt++;
      end else begin
        e = pending_outcomes.pop_front();
        if (read_word_o !== e.read_word) begin
          $error("read_word: expected %0d, got %0d", e.read_word, read_word_o);
          error_cnt++;
        end
        if (hit_o !== e.hit) begin
          $error("hit: expected %0b, got %0b", e.hit, hit_o);
          error_cnt++;
        end
        if (applied_o !== e.applied) begin
          $error("applied: expected %0b, got %0b", e.applied, applied_o);
          error_cnt++;
        end
        if (full_refused_o !== e.full_refused) begin
          $error("full_refused: expected %0b, got %0b", e.full_refused, full_refused_o);
          error_cnt++;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, entry_count_o);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t     rows[$];
    outcome_t none;
    none = '0;
    start = 1'b0;
    action_i = ils_pkg::ACT_READ;
    position_i = '0;
    value_i = '0;
    rst_ni = 1'b0;
    error_cnt = 0;
    beat_cnt = 0;
    item_cnt = 0;
    cycle_cnt = 0;
    idle_en = 1'b1;

    rows = '{
      '{ils_pkg::ACT_READ,   16'd0,    32'sd5,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd0}},
      '{ils_pkg::ACT_DELETE, 16'd0,    32'sd0,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd0}},
      '{ils_pkg::ACT_INSERT, 16'd1,    32'sd9,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd0}},
      '{ils_pkg::ACT_INSERT, 16'd0,    32'sh7fff_ffff, 1'b1, '{-1, 1'b0, 1'b1, 1'b0, 11'd1}},
      '{ils_pkg::ACT_APPEND, 16'hffff, 32'sh8000_0000, 1'b1, '{-1, 1'b0, 1'b1, 1'b0, 11'd2}},
      '{ils_pkg::ACT_FRONT,  16'd7,    -32'sd1,        1'b1, '{-1, 1'b0, 1'b1, 1'b0, 11'd3}},
      '{ils_pkg::ACT_READ,   16'd0,    32'sd0,         1'b1, '{-1, 1'b1, 1'b1, 1'b0, 11'd3}},
      '{ils_pkg::ACT_READ,   16'd2,    32'sd0,         1'b1,
        '{32'sh8000_0000, 1'b1, 1'b1, 1'b0, 11'd3}},
      '{ils_pkg::ACT_INSERT, 16'd3,    32'sd0,         1'b0, '0},
      '{ils_pkg::ACT_INSERT, 16'd1,    32'sd12345,     1'b0, '0},
      '{ils_pkg::ACT_INSERT, 16'hffff, 32'sd1,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{ils_pkg::ACT_READ,   16'd1,    32'sd0,         1'b0, '0},
      '{ils_pkg::ACT_READ,   16'd4,    32'sd0,         1'b0, '0},
      '{ils_pkg::ACT_READ,   16'd5,    32'sd0,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{ils_pkg::ACT_READ,   16'hffff, 32'sd0,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{3'd5,                16'd0,    32'sd3,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{3'd6,                16'd1,    32'sd3,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{3'd7,                16'hffff, -32'sd3,        1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{ils_pkg::ACT_DELETE, 16'hffff, 32'sd0,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{ils_pkg::ACT_DELETE, 16'd5,    32'sd0,         1'b1, '{-1, 1'b0, 1'b0, 1'b0, 11'd5}},
      '{ils_pkg::ACT_DELETE, 16'd4,    32'sd0,         1'b1, '{-1, 1'b0, 1'b1, 1'b0, 11'd4}},
      '{ils_pkg::ACT_DELETE, 16'd0,    32'sd0,         1'b1, '{-1, 1'b0, 1'b1, 1'b0, 11'd3}},
      '{ils_pkg::ACT_READ,   16'd0,    32'sd0,         1'b0, '0},
      '{ils_pkg::ACT_READ,   16'd2,    32'sd0,         1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      send(rows[i].action, rows[i].position, rows[i].value, rows[i].typed, rows[i].outcome);
    end

    repeat (500) send_random(1'b1);

    idle_en = 1'b0;
    repeat (60) send_random(1'b0);

    @(negedge clk_i);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests of every action, checked %0d result beats.",
             item_cnt, beat_cnt);
    $display("Covered the empty list, edge words and positions and unused codes.");
    if (error_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
